// ===== hw/rtl/ckp_pkg.sv =====
// Shared types, constants and letter coding functions for the Cologne phonetic encoder.
package ckp_pkg;

    // Depth of the token queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef logic [4:0] t_letter;
    typedef logic [3:0] t_code;

    // Letters as 1..26, zero means no letter
    localparam t_letter LET_NONE = 5'd0;
    localparam t_letter LET_A = 5'd1;
    localparam t_letter LET_B = 5'd2;
    localparam t_letter LET_C = 5'd3;
    localparam t_letter LET_D = 5'd4;
    localparam t_letter LET_E = 5'd5;
    localparam t_letter LET_F = 5'd6;
    localparam t_letter LET_G = 5'd7;
    localparam t_letter LET_H = 5'd8;
    localparam t_letter LET_I = 5'd9;
    localparam t_letter LET_J = 5'd10;
    localparam t_letter LET_K = 5'd11;
    localparam t_letter LET_L = 5'd12;
    localparam t_letter LET_M = 5'd13;
    localparam t_letter LET_N = 5'd14;
    localparam t_letter LET_O = 5'd15;
    localparam t_letter LET_P = 5'd16;
    localparam t_letter LET_Q = 5'd17;
    localparam t_letter LET_R = 5'd18;
    localparam t_letter LET_S = 5'd19;
    localparam t_letter LET_T = 5'd20;
    localparam t_letter LET_U = 5'd21;
    localparam t_letter LET_V = 5'd22;
    localparam t_letter LET_W = 5'd23;
    localparam t_letter LET_X = 5'd24;
    localparam t_letter LET_Y = 5'd25;
    localparam t_letter LET_Z = 5'd26;

    // Code digits and markers
    localparam t_code CODE_0     = 4'd0;
    localparam t_code CODE_1     = 4'd1;
    localparam t_code CODE_2     = 4'd2;
    localparam t_code CODE_3     = 4'd3;
    localparam t_code CODE_4     = 4'd4;
    localparam t_code CODE_5     = 4'd5;
    localparam t_code CODE_6     = 4'd6;
    localparam t_code CODE_7     = 4'd7;
    localparam t_code CODE_8     = 4'd8;
    localparam t_code CODE_H     = 4'd9;
    localparam t_code CODE_START = 4'd15;

    // UTF-8 bytes of interest
    localparam logic [7:0] BYTE_LEAD_C3  = 8'hC3;
    localparam logic [7:0] BYTE_LEAD_E1  = 8'hE1;
    localparam logic [7:0] BYTE_MID_BA   = 8'hBA;
    localparam logic [7:0] BYTE_AE_UPPER = 8'h84;
    localparam logic [7:0] BYTE_AE_LOWER = 8'hA4;
    localparam logic [7:0] BYTE_OE_UPPER = 8'h96;
    localparam logic [7:0] BYTE_OE_LOWER = 8'hB6;
    localparam logic [7:0] BYTE_UE_UPPER = 8'h9C;
    localparam logic [7:0] BYTE_UE_LOWER = 8'hBC;
    localparam logic [7:0] BYTE_SZ_C3    = 8'h9F;
    localparam logic [7:0] BYTE_SZ_E1    = 8'h9E;
    localparam logic [7:0] BYTE_UC_FIRST = 8'h41;
    localparam logic [7:0] BYTE_UC_LAST  = 8'h5A;
    localparam logic [7:0] BYTE_LC_FIRST = 8'h61;
    localparam logic [7:0] BYTE_LC_LAST  = 8'h7A;

    // Pending UTF-8 lead
    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_C3,
        PFX_E1,
        PFX_E1BA
    } t_prefix;

    // Work for the back end caused by one input byte
    typedef struct packed {
        logic    has_letter;
        logic    two;
        t_letter letter;
        logic    end_word;
    } t_token;

    // Back end sequencing over one token
    typedef enum logic [1:0] {
        PH_LETTER0,
        PH_LETTER1,
        PH_END_CODE,
        PH_END_ITEM
    } t_phase;

    // Coding of one letter: first code, and a trailing 8 for the X case
    typedef struct packed {
        t_code code;
        logic  two;
    } t_class;

    function automatic logic is_zero_class(t_letter c);
        return c == LET_A || c == LET_E || c == LET_I || c == LET_J ||
               c == LET_O || c == LET_U || c == LET_Y;
    endfunction

    // Successors that make an initial C hard
    function automatic logic is_front_hard(t_letter c);
        return c == LET_A || c == LET_H || c == LET_K || c == LET_L || c == LET_O ||
               c == LET_Q || c == LET_R || c == LET_U || c == LET_X;
    endfunction

    // Successors that make an inner C hard
    function automatic logic is_inner_hard(t_letter c);
        return c == LET_A || c == LET_H || c == LET_K || c == LET_O ||
               c == LET_Q || c == LET_U || c == LET_X;
    endfunction

    function automatic t_class classify(t_letter c, t_letter nx, t_letter pv, logic ne);
        t_class r;
        r.code = CODE_H;
        r.two  = 1'b0;
        if (is_zero_class(c)) begin
            r.code = CODE_0;
        end else if (c == LET_B || (c == LET_P && nx != LET_H)) begin
            r.code = CODE_1;
        end else if ((c == LET_D || c == LET_T) &&
                     !(nx == LET_C || nx == LET_S || nx == LET_Z)) begin
            r.code = CODE_2;
        end else if (c == LET_F || c == LET_P || c == LET_V || c == LET_W) begin
            r.code = CODE_3;
        end else if (c == LET_G || c == LET_K || c == LET_Q) begin
            r.code = CODE_4;
        end else if (c == LET_C) begin
            if (ne) begin
                r.code = is_front_hard(nx) ? CODE_4 : CODE_8;
            end else begin
                r.code = ((pv == LET_S || pv == LET_Z) || !is_inner_hard(nx)) ?
                         CODE_8 : CODE_4;
            end
        end else if (c == LET_X && !(pv == LET_C || pv == LET_K || pv == LET_Q)) begin
            r.code = CODE_4;
            r.two  = 1'b1;
        end else if (c == LET_L) begin
            r.code = CODE_5;
        end else if (c == LET_M || c == LET_N) begin
            r.code = CODE_6;
        end else if (c == LET_R) begin
            r.code = CODE_7;
        end else if (c == LET_H) begin
            r.code = CODE_H;
        end else if (c == LET_S || c == LET_Z || c == LET_D || c == LET_T ||
                     c == LET_X) begin
            r.code = CODE_8;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ckp_if.sv =====
// Channel interfaces: raw word bytes in, code result items out.
interface ckp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ckp_code_if;
    logic       valid;
    logic       ready;
    logic [3:0] code_digit;
    logic       has_digit;
    logic       word_end;
    logic       no_letters;

    modport source (output valid, output code_digit, output has_digit,
                    output word_end, output no_letters, input ready);
    modport sink   (input valid, input code_digit, input has_digit,
                    input word_end, input no_letters, output ready);
endinterface

// ===== hw/rtl/ckp_front.sv =====
// Front end: UTF-8 decode and case folding of input bytes into letter tokens.
module ckp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ckp_byte_if.sink         i_byte,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output ckp_pkg::t_token  o_push_token
);

    ckp_pkg::t_prefix r_prefix;
    ckp_pkg::t_prefix n_prefix;
    logic             fresh;
    logic             has_letter;
    logic             two;
    ckp_pkg::t_letter letter;
    logic [7:0]       b;

    assign b = i_byte.data_byte;

    // Classify the byte against any pending lead, then as a fresh byte
    always_comb begin
        fresh      = 1'b1;
        has_letter = 1'b0;
        two        = 1'b0;
        letter     = ckp_pkg::LET_NONE;
        n_prefix   = ckp_pkg::PFX_NONE;
        case (r_prefix)
            ckp_pkg::PFX_C3: begin
                if (b == ckp_pkg::BYTE_AE_UPPER || b == ckp_pkg::BYTE_AE_LOWER) begin
                    has_letter = 1'b1;
                    letter     = ckp_pkg::LET_A;
                    fresh      = 1'b0;
                end else if (b == ckp_pkg::BYTE_OE_UPPER ||
                             b == ckp_pkg::BYTE_OE_LOWER) begin
                    has_letter = 1'b1;
                    letter     = ckp_pkg::LET_O;
                    fresh      = 1'b0;
                end else if (b == ckp_pkg::BYTE_UE_UPPER ||
                             b == ckp_pkg::BYTE_UE_LOWER) begin
                    has_letter = 1'b1;
                    letter     = ckp_pkg::LET_U;
                    fresh      = 1'b0;
                end else if (b == ckp_pkg::BYTE_SZ_C3) begin
                    has_letter = 1'b1;
                    two        = 1'b1;
                    letter     = ckp_pkg::LET_S;
                    fresh      = 1'b0;
                end
            end
            ckp_pkg::PFX_E1: begin
                if (b == ckp_pkg::BYTE_MID_BA) begin
                    n_prefix = ckp_pkg::PFX_E1BA;
                    fresh    = 1'b0;
                end
            end
            ckp_pkg::PFX_E1BA: begin
                if (b == ckp_pkg::BYTE_SZ_E1) begin
                    has_letter = 1'b1;
                    two        = 1'b1;
                    letter     = ckp_pkg::LET_S;
                    fresh      = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (fresh) begin
            if ((b >= ckp_pkg::BYTE_UC_FIRST && b <= ckp_pkg::BYTE_UC_LAST) ||
                (b >= ckp_pkg::BYTE_LC_FIRST && b <= ckp_pkg::BYTE_LC_LAST)) begin
                has_letter = 1'b1;
                letter     = b[4:0];
            end else if (b == ckp_pkg::BYTE_LEAD_C3) begin
                n_prefix = ckp_pkg::PFX_C3;
            end else if (b == ckp_pkg::BYTE_LEAD_E1) begin
                n_prefix = ckp_pkg::PFX_E1;
            end
        end

        // Drop a lead still pending at the end of the word
        if (i_byte.last_byte) begin
            n_prefix = ckp_pkg::PFX_NONE;
        end
    end

    // Push only bytes that give the back end work
    assign i_byte.ready             = i_push_ready;
    assign o_push_valid             = i_byte.valid && (has_letter || i_byte.last_byte);
    assign o_push_token.has_letter  = has_letter;
    assign o_push_token.two         = two;
    assign o_push_token.letter      = letter;
    assign o_push_token.end_word    = i_byte.last_byte;

    // Advance the lead state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= ckp_pkg::PFX_NONE;
        end else if (i_byte.valid && i_push_ready) begin
            r_prefix <= n_prefix;
        end
    end

endmodule

// ===== hw/rtl/ckp_queue.sv =====
// Small token queue that decouples the front end from the back end.
module ckp_queue #(
    parameter int Depth = ckp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  ckp_pkg::t_token  i_push_token,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output ckp_pkg::t_token  o_pop_token
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    ckp_pkg::t_token r_mem [Depth];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CW'(Depth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_token  = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Store pushed tokens
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_token;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(Depth - 1)) ? '0 : r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(Depth - 1)) ? '0 : r_rd + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/ckp_back.sv =====
// Back end: Cologne coding of held letters, repeat merging and result register.
module ckp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pop_valid,
    output logic             o_pop_ready,
    input  ckp_pkg::t_token  i_pop_token,
    ckp_code_if.source       o_code
);

    // Word state
    ckp_pkg::t_letter r_held;
    logic             r_held_valid;
    ckp_pkg::t_letter r_before;
    ckp_pkg::t_code   r_last;
    logic             r_ne;
    logic             r_any;
    logic             r_pend8;
    ckp_pkg::t_letter n_held;
    logic             n_held_valid;
    ckp_pkg::t_letter n_before;
    ckp_pkg::t_code   n_last;
    logic             n_ne;
    logic             n_any;
    logic             n_pend8;

    // Sequencer over one token
    ckp_pkg::t_phase  r_phase;
    ckp_pkg::t_phase  n_phase;
    ckp_pkg::t_phase  cur_phase;
    logic             r_started;
    logic             n_started;

    // Result register
    logic             r_out_valid;
    logic [3:0]       r_digit;
    logic             r_has;
    logic             r_end;
    logic             r_none;
    logic             produce;
    logic [3:0]       res_digit;
    logic             res_has;
    logic             res_end;
    logic             res_none;

    logic             out_free;
    logic             fire;
    logic             coding;
    logic             emit1;
    logic             hold_for8;
    ckp_pkg::t_letter nx;
    ckp_pkg::t_class  cls;

    assign out_free  = !r_out_valid || o_code.ready;
    assign fire      = i_pop_valid && out_free;
    assign cur_phase = r_started ? r_phase :
                       (i_pop_token.has_letter ? ckp_pkg::PH_LETTER0 : ckp_pkg::PH_END_CODE);

    // Code the held letter against the incoming one, or none at word end
    assign coding = (cur_phase != ckp_pkg::PH_END_ITEM) && r_held_valid && !r_pend8;
    assign nx     = (cur_phase == ckp_pkg::PH_END_CODE) ? ckp_pkg::LET_NONE
                                                        : i_pop_token.letter;
    assign cls    = ckp_pkg::classify(r_held, nx, r_before, r_ne);
    assign emit1  = (cls.code != ckp_pkg::CODE_H) && (cls.code != r_last) &&
                    ((cls.code != ckp_pkg::CODE_0) || r_ne);
    assign hold_for8 = coding && cls.two && emit1;

    // Next phase and token pop
    always_comb begin
        n_phase     = r_phase;
        n_started   = r_started;
        o_pop_ready = 1'b0;
        if (fire) begin
            if (hold_for8) begin
                n_phase   = cur_phase;
                n_started = 1'b1;
            end else begin
                n_started = 1'b1;
                case (cur_phase)
                    ckp_pkg::PH_LETTER0: begin
                        if (i_pop_token.two) begin
                            n_phase = ckp_pkg::PH_LETTER1;
                        end else if (i_pop_token.end_word) begin
                            n_phase = ckp_pkg::PH_END_CODE;
                        end else begin
                            n_started   = 1'b0;
                            o_pop_ready = 1'b1;
                        end
                    end
                    ckp_pkg::PH_LETTER1: begin
                        if (i_pop_token.end_word) begin
                            n_phase = ckp_pkg::PH_END_CODE;
                        end else begin
                            n_started   = 1'b0;
                            o_pop_ready = 1'b1;
                        end
                    end
                    ckp_pkg::PH_END_CODE: begin
                        n_phase = ckp_pkg::PH_END_ITEM;
                    end
                    default: begin
                        n_started   = 1'b0;
                        o_pop_ready = 1'b1;
                    end
                endcase
            end
        end
    end

    // Result item and word state update for the current phase
    always_comb begin
        produce      = 1'b0;
        res_digit    = ckp_pkg::CODE_0;
        res_has      = 1'b0;
        res_end      = 1'b0;
        res_none     = 1'b0;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_before     = r_before;
        n_last       = r_last;
        n_ne         = r_ne;
        n_any        = r_any;
        n_pend8      = r_pend8;
        if (fire) begin
            if (r_pend8) begin
                // Second digit of an X
                produce   = 1'b1;
                res_digit = ckp_pkg::CODE_8;
                res_has   = 1'b1;
                n_pend8   = 1'b0;
            end else if (cur_phase == ckp_pkg::PH_END_ITEM) begin
                produce      = 1'b1;
                res_end      = 1'b1;
                res_none     = !r_any;
                n_held       = ckp_pkg::LET_NONE;
                n_held_valid = 1'b0;
                n_before     = ckp_pkg::LET_NONE;
                n_last       = ckp_pkg::CODE_START;
                n_ne         = 1'b1;
                n_any        = 1'b0;
            end else begin
                if (coding) begin
                    if (emit1 || cls.two) begin
                        produce   = 1'b1;
                        res_has   = 1'b1;
                        res_digit = emit1 ? cls.code : ckp_pkg::CODE_8;
                    end
                    n_last  = cls.two ? ckp_pkg::CODE_8 : cls.code;
                    n_ne    = r_ne && !emit1 && !cls.two;
                    n_pend8 = hold_for8;
                end
                if (cur_phase != ckp_pkg::PH_END_CODE) begin
                    if (r_held_valid) begin
                        n_before = r_held;
                    end
                    n_held       = i_pop_token.letter;
                    n_held_valid = 1'b1;
                    n_any        = 1'b1;
                end
            end
        end
    end

    // Hold word state and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= ckp_pkg::LET_NONE;
            r_held_valid <= 1'b0;
            r_before     <= ckp_pkg::LET_NONE;
            r_last       <= ckp_pkg::CODE_START;
            r_ne         <= 1'b1;
            r_any        <= 1'b0;
            r_pend8      <= 1'b0;
            r_phase      <= ckp_pkg::PH_LETTER0;
            r_started    <= 1'b0;
        end else begin
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_before     <= n_before;
            r_last       <= n_last;
            r_ne         <= n_ne;
            r_any        <= n_any;
            r_pend8      <= n_pend8;
            r_phase      <= n_phase;
            r_started    <= n_started;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (produce) begin
            r_out_valid <= 1'b1;
        end else if (o_code.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_digit <= res_digit;
            r_has   <= res_has;
            r_end   <= res_end;
            r_none  <= res_none;
        end
    end

    assign o_code.valid      = r_out_valid;
    assign o_code.code_digit = r_digit;
    assign o_code.has_digit  = r_has;
    assign o_code.word_end   = r_end;
    assign o_code.no_letters = r_none;

endmodule

// ===== hw/rtl/cologne_phonetic_encoder_top.sv =====
// Top level of the Cologne phonetic encoder: front end, token queue, back end.
//
//  Channel  Dir  Fields                                        Accepted when
//  i_byte   in   data_byte[7:0], last_byte                     valid && ready
//  o_code   out  code_digit[3:0], has_digit, word_end,         valid && ready
//                no_letters
//
// A byte is taken every cycle while the token queue has room; ready depends
// on the queue fill only. The back end works through each token in steps:
// one per letter, another for the second S of a sharp s, another when an X
// gives two digits, and a last code and an end item at the end of a word; the
// back end's sequencer sets the sustained rate, the queue absorbs the bursts.
// Results leave from a register, so a stalled output holds the back end, and
// the input only once the queue is full. Reset is synchronous.
module cologne_phonetic_encoder_top #(
    parameter int QueueDepth = ckp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ckp_byte_if.sink    i_byte,
    ckp_code_if.source  o_code
);

    logic            push_valid;
    logic            push_ready;
    ckp_pkg::t_token push_token;
    logic            pop_valid;
    logic            pop_ready;
    ckp_pkg::t_token pop_token;

    ckp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_token (push_token)
    );

    ckp_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_token (push_token),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_token  (pop_token)
    );

    ckp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_token (pop_token),
        .o_code      (o_code)
    );

endmodule

// ===== hw/rtl/ckp_checker.sv =====
// Port-level checks on the encoder's result channel, bound to the top level.
module ckp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_code_digit,
    input logic       i_has_digit,
    input logic       i_word_end,
    input logic       i_no_letters
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_code_digit, i_has_digit, i_word_end, i_no_letters}))
        else $error("result changed while stalled");

    // A digit item carries a real digit and no end flags
    a_digit_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_has_digit |->
        i_code_digit <= 4'd8 && !i_word_end && !i_no_letters)
        else $error("malformed digit item");

    // An end item carries no digit
    a_end_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_word_end |-> !i_has_digit && i_code_digit == 4'd0)
        else $error("end item carries a digit");

    // Every result is either a digit or an end item
    a_item_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_has_digit != i_word_end)
        else $error("result is neither digit nor end");

endmodule

bind cologne_phonetic_encoder_top ckp_checker u_ckp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_code.valid),
    .i_out_ready  (o_code.ready),
    .i_code_digit (o_code.code_digit),
    .i_has_digit  (o_code.has_digit),
    .i_word_end   (o_code.word_end),
    .i_no_letters (o_code.no_letters)
);

// ===== tb/tb_cologne_phonetic_encoder_top.sv =====
// Self-checking testbench for the Cologne phonetic encoder: directed words, random words, stalls.
module tb_cologne_phonetic_encoder_top;

    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int TAIL_CYCLES      = 20;

    // One result transaction as seen on the output channel
    typedef struct packed {
        ckp_pkg::t_code code_digit;
        logic           has_digit;
        logic           word_end;
        logic           no_letters;
    } t_code_item;

    logic i_clk;
    logic i_rst_n;

    ckp_byte_if byte_ch ();
    ckp_code_if code_ch ();

    cologne_phonetic_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_code  (code_ch)
    );

    // Codes still to arrive, oldest first
    t_code_item code_q[$];

    // Encoder state mirrored by the predictor
    ckp_pkg::t_prefix enc_pfx;
    ckp_pkg::t_letter enc_held;
    logic             enc_held_ok;
    ckp_pkg::t_letter enc_prev;
    ckp_pkg::t_code   enc_last_code;
    logic             enc_no_digit;
    logic             enc_seen_letter;

    int fail_count;
    int bytes_sent;
    bit src_idle_en;
    bit sink_idle_en;
    bit long_hold;

    // Toggle the clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic bit letter_in(ckp_pkg::t_letter v, string letters);
        if (v == ckp_pkg::LET_NONE) return 1'b0;
        for (int i = 0; i < letters.len(); i++) begin
            if (letters[i] == (8'h40 + 8'(v))) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_word();
        enc_pfx         = ckp_pkg::PFX_NONE;
        enc_held        = ckp_pkg::LET_NONE;
        enc_held_ok     = 1'b0;
        enc_prev        = ckp_pkg::LET_NONE;
        enc_last_code   = ckp_pkg::CODE_START;
        enc_no_digit    = 1'b1;
        enc_seen_letter = 1'b0;
    endfunction

    // Merge repeats, keep a zero only as the first digit, let H break a run
    function automatic void put_digit(ckp_pkg::t_code code);
        if (code != ckp_pkg::CODE_H && code != enc_last_code &&
            (code != ckp_pkg::CODE_0 || enc_no_digit)) begin
            code_q.insert(code_q.size(), t_code_item'({code, 1'b1, 1'b0, 1'b0}));
            enc_no_digit = 1'b0;
        end
        enc_last_code = code;
    endfunction

    function automatic void code_letter(ckp_pkg::t_letter c, ckp_pkg::t_letter nx);
        if (letter_in(c, "AEIJOUY")) begin
            put_digit(ckp_pkg::CODE_0);
        end else if (c == ckp_pkg::LET_B || (c == ckp_pkg::LET_P && nx != ckp_pkg::LET_H)) begin
            put_digit(ckp_pkg::CODE_1);
        end else if (letter_in(c, "DT") && !letter_in(nx, "CSZ")) begin
            put_digit(ckp_pkg::CODE_2);
        end else if (letter_in(c, "FPVW")) begin
            put_digit(ckp_pkg::CODE_3);
        end else if (letter_in(c, "GKQ")) begin
            put_digit(ckp_pkg::CODE_4);
        end else if (c == ckp_pkg::LET_C) begin
            if (enc_no_digit) begin
                put_digit(letter_in(nx, "AHKLOQRUX") ? ckp_pkg::CODE_4 : ckp_pkg::CODE_8);
            end else begin
                put_digit((letter_in(enc_prev, "SZ") || !letter_in(nx, "AHKOQUX")) ?
                          ckp_pkg::CODE_8 : ckp_pkg::CODE_4);
            end
        end else if (c == ckp_pkg::LET_X && !letter_in(enc_prev, "CKQ")) begin
            put_digit(ckp_pkg::CODE_4);
            put_digit(ckp_pkg::CODE_8);
        end else if (c == ckp_pkg::LET_L) begin
            put_digit(ckp_pkg::CODE_5);
        end else if (letter_in(c, "MN")) begin
            put_digit(ckp_pkg::CODE_6);
        end else if (c == ckp_pkg::LET_R) begin
            put_digit(ckp_pkg::CODE_7);
        end else if (c == ckp_pkg::LET_H) begin
            put_digit(ckp_pkg::CODE_H);
        end else if (letter_in(c, "SZDTX")) begin
            put_digit(ckp_pkg::CODE_8);
        end
    endfunction

    // Code the held letter now that its successor is known, then hold the new one
    function automatic void take_letter(ckp_pkg::t_letter v);
        if (enc_held_ok) begin
            code_letter(enc_held, v);
            enc_prev = enc_held;
        end
        enc_held        = v;
        enc_held_ok     = 1'b1;
        enc_seen_letter = 1'b1;
    endfunction

    function automatic void encode_byte(logic [7:0] b, logic is_last);
        bit fresh;
        fresh = 1'b1;
        case (enc_pfx)
            ckp_pkg::PFX_C3: begin
                enc_pfx = ckp_pkg::PFX_NONE;
                if (b == ckp_pkg::BYTE_AE_UPPER || b == ckp_pkg::BYTE_AE_LOWER) begin
                    take_letter(ckp_pkg::LET_A);
                    fresh = 1'b0;
                end else if (b == ckp_pkg::BYTE_OE_UPPER || b == ckp_pkg::BYTE_OE_LOWER) begin
                    take_letter(ckp_pkg::LET_O);
                    fresh = 1'b0;
                end else if (b == ckp_pkg::BYTE_UE_UPPER || b == ckp_pkg::BYTE_UE_LOWER) begin
                    take_letter(ckp_pkg::LET_U);
                    fresh = 1'b0;
                end else if (b == ckp_pkg::BYTE_SZ_C3) begin
                    take_letter(ckp_pkg::LET_S);
                    take_letter(ckp_pkg::LET_S);
                    fresh = 1'b0;
                end
            end
            ckp_pkg::PFX_E1: begin
                enc_pfx = ckp_pkg::PFX_NONE;
                if (b == ckp_pkg::BYTE_MID_BA) begin
                    enc_pfx = ckp_pkg::PFX_E1BA;
                    fresh   = 1'b0;
                end
            end
            ckp_pkg::PFX_E1BA: begin
                enc_pfx = ckp_pkg::PFX_NONE;
                if (b == ckp_pkg::BYTE_SZ_E1) begin
                    take_letter(ckp_pkg::LET_S);
                    take_letter(ckp_pkg::LET_S);
                    fresh = 1'b0;
                end
            end
            default: ;
        endcase

        // A byte that broke a lead is looked at again from scratch
        if (fresh) begin
            if (b >= ckp_pkg::BYTE_UC_FIRST && b <= ckp_pkg::BYTE_UC_LAST) begin
                take_letter(ckp_pkg::t_letter'(b - ckp_pkg::BYTE_UC_FIRST + 8'd1));
            end else if (b >= ckp_pkg::BYTE_LC_FIRST && b <= ckp_pkg::BYTE_LC_LAST) begin
                take_letter(ckp_pkg::t_letter'(b - ckp_pkg::BYTE_LC_FIRST + 8'd1));
            end else if (b == ckp_pkg::BYTE_LEAD_C3) begin
                enc_pfx = ckp_pkg::PFX_C3;
            end else if (b == ckp_pkg::BYTE_LEAD_E1) begin
                enc_pfx = ckp_pkg::PFX_E1;
            end
        end

        // Flush the held letter and close the word
        if (is_last) begin
            if (enc_held_ok) code_letter(enc_held, ckp_pkg::LET_NONE);
            code_q.insert(code_q.size(),
                          t_code_item'({ckp_pkg::CODE_0, 1'b0, 1'b1, !enc_seen_letter}));
            clear_word();
        end
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Offer one byte, optionally after an idle burst, and predict on acceptance
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= is_last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        encode_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [7:0] word_q[$]);
        for (int i = 0; i < word_q.size(); i++) begin
            send_byte(word_q[i], i == word_q.size() - 1);
        end
    endtask

    // Build a mostly well-formed word: letters, umlauts, sharp s, with noise and broken leads
    task automatic send_random_word();
        logic [7:0]       word_q[$];
        int               units;
        int               pick;
        ckp_pkg::t_letter v;
        string            favour;
        favour = "CXHPDTSZKQ";
        units  = $urandom_range(1, 8);
        repeat (units) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if ($urandom_range(0, 1)) begin
                    v = ckp_pkg::t_letter'($urandom_range(1, 26));
                end else begin
                    v = ckp_pkg::t_letter'(favour[$urandom_range(0, favour.len() - 1)] - 8'h40);
                end
                word_q.insert(word_q.size(),
                              ($urandom_range(0, 1) ? ckp_pkg::BYTE_UC_FIRST
                                                    : ckp_pkg::BYTE_LC_FIRST) +
                              8'(v) - 8'd1);
            end else if (pick < 70) begin
                word_q.insert(word_q.size(), ckp_pkg::BYTE_LEAD_C3);
                case ($urandom_range(0, 5))
                    0: word_q.insert(word_q.size(), ckp_pkg::BYTE_AE_UPPER);
                    1: word_q.insert(word_q.size(), ckp_pkg::BYTE_AE_LOWER);
                    2: word_q.insert(word_q.size(), ckp_pkg::BYTE_OE_UPPER);
                    3: word_q.insert(word_q.size(), ckp_pkg::BYTE_OE_LOWER);
                    4: word_q.insert(word_q.size(), ckp_pkg::BYTE_UE_UPPER);
                    default: word_q.insert(word_q.size(), ckp_pkg::BYTE_UE_LOWER);
                endcase
            end else if (pick < 76) begin
                if ($urandom_range(0, 1)) begin
                    word_q.insert(word_q.size(), ckp_pkg::BYTE_LEAD_C3);
                    word_q.insert(word_q.size(), ckp_pkg::BYTE_SZ_C3);
                end else begin
                    word_q.insert(word_q.size(), ckp_pkg::BYTE_LEAD_E1);
                    word_q.insert(word_q.size(), ckp_pkg::BYTE_MID_BA);
                    word_q.insert(word_q.size(), ckp_pkg::BYTE_SZ_E1);
                end
            end else if (pick < 88) begin
                word_q.insert(word_q.size(), 8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 2))
                    0: word_q.insert(word_q.size(), ckp_pkg::BYTE_LEAD_C3);
                    1: word_q.insert(word_q.size(), ckp_pkg::BYTE_LEAD_E1);
                    default: begin
                        word_q.insert(word_q.size(), ckp_pkg::BYTE_LEAD_E1);
                        word_q.insert(word_q.size(), ckp_pkg::BYTE_MID_BA);
                    end
                endcase
                word_q.insert(word_q.size(), 8'($urandom_range(0, 255)));
            end
        end
        // Now and then leave a lead dangling at the end of the word
        if ($urandom_range(0, 15) == 0) begin
            word_q.insert(word_q.size(), $urandom_range(0, 1) ? ckp_pkg::BYTE_LEAD_C3
                                                              : ckp_pkg::BYTE_LEAD_E1);
        end
        send_word(word_q);
    endtask

    task automatic run_words(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) send_random_word();
    endtask

    // ------------------------------------------------------------------
    // Sink side
    // ------------------------------------------------------------------

    // Drive ready: a long hold on request, random stall bursts when enabled
    initial begin : drive_ready
        int gap;
        code_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                code_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                long_hold = 1'b0;
                code_ch.ready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 14);
                code_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
                code_ch.ready <= 1'b1;
            end else begin
                code_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_code_item want;
        if (i_rst_n && code_ch.valid && code_ch.ready) begin
            if (code_q.size() == 0) begin
                $display({"%0t: unexpected result: expected no result, ",
                          "got digit=%0d has=%0b end=%0b none=%0b"},
                         $time, code_ch.code_digit, code_ch.has_digit,
                         code_ch.word_end, code_ch.no_letters);
                fail_count++;
            end else begin
                want = code_q.pop_front();
                if (want.code_digit !== code_ch.code_digit ||
                    want.has_digit  !== code_ch.has_digit  ||
                    want.word_end   !== code_ch.word_end   ||
                    want.no_letters !== code_ch.no_letters) begin
                    $display({"%0t: result mismatch: expected digit=%0d has=%0b end=%0b ",
                              "none=%0b, got digit=%0d has=%0b end=%0b none=%0b"},
                             $time, want.code_digit, want.has_digit, want.word_end,
                             want.no_letters, code_ch.code_digit, code_ch.has_digit,
                             code_ch.word_end, code_ch.no_letters);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Word of bytes that are never letters, at both ends of the byte range
    task automatic test_no_letters();
        send_word('{8'h00, 8'hFF});
    endtask

    // A lone H is a letter that codes to nothing
    task automatic test_silent_letters();
        send_word('{"h"});
    endtask

    // Initial C before A, X after a vowel, then each coding class at least once
    task automatic test_code_classes();
        send_word('{"C", "a", "x", "b", "P", "h", "D", "z", "T", "l", "m", "R", "w",
                    "G", "s"});
    endtask

    // Two umlauts and the three-byte sharp s form
    task automatic test_utf8_folding();
        send_word('{ckp_pkg::BYTE_LEAD_C3, ckp_pkg::BYTE_UE_UPPER, ckp_pkg::BYTE_LEAD_E1,
                    ckp_pkg::BYTE_MID_BA, ckp_pkg::BYTE_SZ_E1, ckp_pkg::BYTE_LEAD_C3,
                    ckp_pkg::BYTE_AE_LOWER});
    endtask

    // Leads broken by letters, and a lead left pending at the end of the word
    task automatic test_mismatched_lead();
        send_word('{ckp_pkg::BYTE_LEAD_C3, "z", ckp_pkg::BYTE_LEAD_E1, ckp_pkg::BYTE_MID_BA,
                    "k", ckp_pkg::BYTE_LEAD_C3});
    endtask

    // Hold the output long enough for the block to fill and stall its input
    task automatic test_backpressure();
        long_hold = 1'b1;
        run_words(40);
    endtask

    // Random words under each mix of idling on the two sides
    task automatic test_random_words();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        run_words(100);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_words(100);
        src_idle_en  = 1'b1;
        run_words(100);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b1;
        run_words(100);
    endtask

    // Back-to-back words with no idling at all
    task automatic test_steady_tail();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_words(100);
    endtask

    initial begin : run_tests
        int waited;
        clear_word();
        fail_count        = 0;
        bytes_sent        = 0;
        long_hold         = 1'b0;
        src_idle_en       = 1'b1;
        sink_idle_en      = 1'b1;
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.last_byte = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_no_letters();
        test_silent_letters();
        test_code_classes();
        test_utf8_folding();
        test_mismatched_lead();
        test_backpressure();
        test_random_words();
        test_steady_tail();

        // Drop valid, then wait for the outstanding codes
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        waited = 0;
        while (code_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (code_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, code_q.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
